FILE: design/scft_pkg.sv
// ----------------------------------------------------------------------------
// scft_pkg: shared types and constants of the sorted chunk frequency table
// Field widths of the stream items, result status codes and the control and
// flag bundles passed between the top level and the table cells.
// ----------------------------------------------------------------------------
package scft_pkg;

    // field widths of one input item
    localparam int OP_W      = 1;
    localparam int CHUNK_W   = 16;
    localparam int CLEN_W    = 5;
    localparam int EIDX_W    = 8;
    localparam int IN_DATA_W = 32;   // 29 bits of fields, padded to bytes

    // field widths of one result item
    localparam int STAT_W     = 3;
    localparam int POS_W      = 8;
    localparam int OCC_W      = 32;
    localparam int EVAL_W     = 16;
    localparam int ELEN_W     = 5;
    localparam int DCNT_W     = 9;
    localparam int OUT_DATA_W = 72;  // 70 bits of fields, padded to bytes

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_COUNTED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_OUT_RNG  = 3'd4
    } t_status;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp;   // compare stored key against the item
        logic hit;   // bump the count of the matching cell
        logic ins;   // insert the new chunk, shift larger entries up
    } t_cell_ctl;

    // registered compare flags of one cell
    typedef struct packed {
        logic ge;    // valid and stored key not below the item key
        logic eq;    // valid and stored key equal to the item key
        logic rd;    // valid and this cell is the read index
    } t_cell_flag;

endpackage

FILE: design/scft_cell.sv
// ----------------------------------------------------------------------------
// scft_cell: one entry of the sorted table
// Holds key, length and count of one table position, compares its key against
// the broadcast item, and on insert takes its lower neighbor's entry or the
// new chunk.
// ----------------------------------------------------------------------------
module scft_cell #(
    parameter int IDX        = 0,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 32,
    parameter int USED_W     = 9
) (
    input  logic                   i_clk,
    input  scft_pkg::t_cell_ctl    i_ctl,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [4:0]             i_len,
    input  logic [7:0]             i_index,
    input  logic [USED_W-1:0]      i_used,
    input  logic                   i_prev_ge,
    input  logic [KEY_BITS-1:0]    i_prev_key,
    input  logic [4:0]             i_prev_len,
    input  logic [COUNT_BITS-1:0]  i_prev_cnt,
    output scft_pkg::t_cell_flag   o_flag,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [4:0]             o_len,
    output logic [COUNT_BITS-1:0]  o_cnt
);
    import scft_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [KEY_BITS-1:0]   r_key;
    logic [4:0]            r_len;
    logic [COUNT_BITS-1:0] r_cnt;
    t_cell_flag            r_flag;
    logic                  w_valid;
    logic                  w_at_end;

    assign w_valid  = 32'(i_used) > IDX;
    assign w_at_end = 32'(i_used) == IDX;

    // compare flags and entry update
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_flag.ge <= w_valid && !(r_key < i_key);
            r_flag.eq <= w_valid && (r_key == i_key);
            r_flag.rd <= w_valid && (32'(i_index) == IDX);
        end
        if (i_ctl.hit && r_flag.eq && r_cnt != CNT_MAX) begin
            r_cnt <= r_cnt + CNT_ONE;
        end
        if (i_ctl.ins) begin
            if (i_prev_ge) begin
                // shift up from the neighbor below
                r_key <= i_prev_key;
                r_len <= i_prev_len;
                r_cnt <= i_prev_cnt;
            end else if (r_flag.ge || w_at_end) begin
                // first entry not below the key, or the first free cell: take the new chunk
                r_key <= i_key;
                r_len <= i_len;
                r_cnt <= CNT_ONE;
            end
        end
    end

    assign o_flag = r_flag;
    assign o_key  = r_key;
    assign o_len  = r_len;
    assign o_cnt  = r_cnt;

endmodule

FILE: design/sorted_chunk_frequency_table.sv
// Flow: an accepted item passes the compare, select and update states;
//   the update waits while an earlier result is still not taken, then
//   the result holds until taken. A new item is taken only in the idle
//   state, after the last one is done; the cell row compares and shifts all
//   entries in parallel, so the time per item does not depend on table fill.
// Reset: synchronous, active low; clears the sequencer, the entry count and
//   the result valid flag. Cell contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_chunk_frequency_table: sorted table of chunks with occurrence counts
// A row of cells holds the entries in ascending key order. Add items count a
// hit or insert in place; read items return the entry at an index.
// ----------------------------------------------------------------------------
module sorted_chunk_frequency_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // chunk_value[15:0], chunk_length[20:16], entry_index[28:21], zero pad
    input  logic [scft_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation[0]
    input  logic [scft_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // position[7:0], occurrences[39:8], entry_value[55:40],
    // entry_length[60:56], distinct_count[69:61], zero pad
    output logic [scft_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[2:0]
    output logic [scft_pkg::STAT_W-1:0]        m_axis_tuser
);
    import scft_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } t_state;

    t_state r_state;

    // captured item
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [4:0]            r_len;
    logic [EIDX_W-1:0]     r_idx;
    logic [USED_W-1:0]     r_used;

    // selected entry
    logic                  r_hit;
    logic                  r_any;
    logic [IDX_W-1:0]      r_pos;
    logic [KEY_BITS-1:0]   r_skey;
    logic [4:0]            r_slen;
    logic [COUNT_BITS-1:0] r_scnt;

    // result register
    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_out_stat;
    logic [POS_W-1:0]      r_out_pos;
    logic [OCC_W-1:0]      r_out_occ;
    logic [EVAL_W-1:0]     r_out_val;
    logic [ELEN_W-1:0]     r_out_len;
    logic [DCNT_W-1:0]     r_out_dcnt;

    // cell row
    t_cell_flag            w_flag [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   w_ckey [TABLE_DEPTH];
    logic [4:0]            w_clen [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] w_ccnt [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_eq_vec;
    t_cell_ctl             w_ctl;

    logic                  w_accept;
    logic                  w_upd_go;
    logic                  w_full;
    logic [4:0]            w_len_clamp;
    logic [TABLE_DEPTH-1:0] w_pick;
    logic                  n_hit;
    logic                  n_any;
    logic [IDX_W-1:0]      n_pos;
    logic [KEY_BITS-1:0]   n_skey;
    logic [4:0]            n_slen;
    logic [COUNT_BITS-1:0] n_scnt;
    logic [COUNT_BITS-1:0] w_cnt_inc;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_upd_go    = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);
    assign w_full      = 32'(r_used) >= TABLE_DEPTH;
    assign w_len_clamp = (32'(r_len) > KEY_BITS) ? 5'(KEY_BITS) : r_len;
    assign w_cnt_inc   = (r_scnt == CNT_MAX) ? r_scnt : r_scnt + CNT_ONE;

    // broadcast control to the cells
    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.hit = w_upd_go && (r_op == OP_ADD) && r_hit;
        w_ctl.ins = w_upd_go && (r_op == OP_ADD) && !r_hit && !w_full;
    end

    // build the cell row
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic                  w_pge;
        logic [KEY_BITS-1:0]   w_pkey;
        logic [4:0]            w_plen;
        logic [COUNT_BITS-1:0] w_pcnt;
        if (k == 0) begin : g_first
            assign w_pge  = 1'b0;
            assign w_pkey = '0;
            assign w_plen = '0;
            assign w_pcnt = '0;
        end else begin : g_rest
            assign w_pge  = w_flag[k-1].ge;
            assign w_pkey = w_ckey[k-1];
            assign w_plen = w_clen[k-1];
            assign w_pcnt = w_ccnt[k-1];
        end
        scft_cell #(
            .IDX        (k),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS),
            .USED_W     (USED_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_len      (w_len_clamp),
            .i_index    (r_idx),
            .i_used     (r_used),
            .i_prev_ge  (w_pge),
            .i_prev_key (w_pkey),
            .i_prev_len (w_plen),
            .i_prev_cnt (w_pcnt),
            .o_flag     (w_flag[k]),
            .o_key      (w_ckey[k]),
            .o_len      (w_clen[k]),
            .o_cnt      (w_ccnt[k])
        );
        assign w_eq_vec[k] = w_flag[k].eq;
        // read picks the index cell; add picks the first cell not below key
        assign w_pick[k] = (r_op == OP_READ) ? w_flag[k].rd
                                             : (w_flag[k].ge && !w_pge);
    end

    // gather the picked entry and its position
    always_comb begin
        n_hit  = |w_eq_vec;
        n_any  = |w_pick;
        n_pos  = '0;
        n_skey = '0;
        n_slen = '0;
        n_scnt = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (w_pick[k]) begin
                n_pos  = n_pos  | IDX_W'(k);
                n_skey = n_skey | w_ckey[k];
                n_slen = n_slen | w_clen[k];
                n_scnt = n_scnt | w_ccnt[k];
            end
        end
    end

    // sequencer, entry count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise the result flag on update, drop it once taken
            if (w_upd_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_upd_go) begin
                        r_state <= S_IDLE;
                        if (w_ctl.ins) begin
                            r_used <= r_used + USED_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // hold the accepted item
        if (w_accept) begin
            r_op  <= t_op'(s_axis_tuser);
            r_key <= KEY_BITS'(s_axis_tdata[CHUNK_W-1:0]);
            r_len <= s_axis_tdata[CHUNK_W +: CLEN_W];
            r_idx <= s_axis_tdata[CHUNK_W+CLEN_W +: EIDX_W];
        end

        // hold the selected entry
        if (r_state == S_SEL) begin
            r_hit  <= n_hit;
            r_any  <= n_any;
            r_pos  <= n_pos;
            r_skey <= n_skey;
            r_slen <= n_slen;
            r_scnt <= n_scnt;
        end

        // build the result
        if (w_upd_go) begin
            r_out_dcnt <= w_ctl.ins ? DCNT_W'(r_used + USED_W'(1)) : DCNT_W'(r_used);
            if (r_op == OP_READ) begin
                r_out_pos <= r_idx;
                if (r_any) begin
                    r_out_stat <= ST_READ_OK;
                    r_out_occ  <= OCC_W'(r_scnt);
                    r_out_val  <= EVAL_W'(r_skey);
                    r_out_len  <= r_slen;
                end else begin
                    r_out_stat <= ST_OUT_RNG;
                    r_out_occ  <= '0;
                    r_out_val  <= '0;
                    r_out_len  <= '0;
                end
            end else if (r_hit) begin
                r_out_stat <= ST_COUNTED;
                r_out_pos  <= POS_W'(r_pos);
                r_out_occ  <= OCC_W'(w_cnt_inc);
                r_out_val  <= EVAL_W'(r_skey);
                r_out_len  <= r_slen;
            end else if (w_full) begin
                r_out_stat <= ST_FULL;
                r_out_pos  <= '0;
                r_out_occ  <= '0;
                r_out_val  <= '0;
                r_out_len  <= '0;
            end else begin
                r_out_stat <= ST_INSERTED;
                r_out_pos  <= r_any ? POS_W'(r_pos) : POS_W'(r_used);
                r_out_occ  <= OCC_W'(CNT_ONE);
                r_out_val  <= EVAL_W'(r_key);
                r_out_len  <= w_len_clamp;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tdata  = {(OUT_DATA_W - POS_W - OCC_W - EVAL_W - ELEN_W - DCNT_W)'(0),
                            r_out_dcnt, r_out_len, r_out_val, r_out_occ, r_out_pos};

    // entry count never passes the table depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= TABLE_DEPTH)
        else $error("entry count above table depth");

    // an insert grows the table by exactly one entry
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> r_used == $past(r_used) + USED_W'(1))
        else $error("insert did not grow the table by one");

    // distinct keys: at most one cell matches
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> $onehot0(w_eq_vec))
        else $error("more than one cell matches the key");

    // a full report only comes from a full table
    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> 32'(r_used) == TABLE_DEPTH)
        else $error("full reported while the table has room");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted chunk frequency table
// Drives add and read items on the input stream and checks every result item
// against a behavioral table kept here. Covers empty-table reads, inserts at
// both ends and in the middle, hits that keep the stored length, length
// clamping, a table filled to capacity with drops, and random traffic with
// random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import scft_pkg::*;

    localparam int TABLE_SLOTS  = 256;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int IDLE_PCT     = 18;
    localparam int POOL_SIZE    = 40;

    // one expected result item
    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic [OCC_W-1:0]    occurrences;
        logic [EVAL_W-1:0]   entry_value;
        logic [ELEN_W-1:0]   entry_length;
        logic [DCNT_W-1:0]   distinct_count;
    } t_table_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // chunk_value[15:0], chunk_length[20:16], entry_index[28:21], zero pad
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    // operation[0]
    logic [OP_W-1:0]         s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // position[7:0], occurrences[39:8], entry_value[55:40],
    // entry_length[60:56], distinct_count[69:61], zero pad
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    // status[2:0]
    logic [STAT_W-1:0]       m_axis_tuser;

    // behavioral copy of the table
    logic [CHUNK_W-1:0]      table_keys [TABLE_SLOTS];
    logic [ELEN_W-1:0]       table_lengths [TABLE_SLOTS];
    logic [OCC_W-1:0]        table_counts [TABLE_SLOTS];
    int                      table_used = 0;

    t_table_result           pending_table_results [$];
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    bit                      quiet_run = 1'b0;

    sorted_chunk_frequency_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // stall the result side at random, except in quiet stretches
    always @(negedge i_clk) begin
        m_axis_tready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end

    // bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // apply one accepted item to the table copy and return its result
    function automatic t_table_result apply_chunk_item(
        input t_op                op,
        input logic [CHUNK_W-1:0] chunk,
        input logic [CLEN_W-1:0]  clen,
        input logic [EIDX_W-1:0]  idx
    );
        t_table_result     r;
        int                slot;
        int                k;
        logic [ELEN_W-1:0] stored_len;
        r = '0;
        slot = 0;
        stored_len = (clen > CHUNK_W) ? ELEN_W'(CHUNK_W) : clen;
        if (op == OP_READ) begin
            r.position = idx;
            if (int'(idx) < table_used) begin
                r.status       = ST_READ_OK;
                r.occurrences  = table_counts[idx];
                r.entry_value  = table_keys[idx];
                r.entry_length = table_lengths[idx];
            end else begin
                r.status = ST_OUT_RNG;
            end
        end else begin
            // find the first entry not below the chunk
            while (slot < table_used && table_keys[slot] < chunk)
                slot++;
            if (slot < table_used && table_keys[slot] == chunk) begin
                if (table_counts[slot] != '1)
                    table_counts[slot] = table_counts[slot] + 1'b1;
                r.status       = ST_COUNTED;
                r.position     = POS_W'(slot);
                r.occurrences  = table_counts[slot];
                r.entry_value  = table_keys[slot];
                r.entry_length = table_lengths[slot];
            end else if (table_used >= TABLE_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                // shift larger entries up and drop the chunk in
                for (k = table_used; k > slot; k--) begin
                    table_keys[k]    = table_keys[k-1];
                    table_lengths[k] = table_lengths[k-1];
                    table_counts[k]  = table_counts[k-1];
                end
                table_keys[slot]    = chunk;
                table_lengths[slot] = stored_len;
                table_counts[slot]  = OCC_W'(1);
                table_used++;
                r.status       = ST_INSERTED;
                r.position     = POS_W'(slot);
                r.occurrences  = OCC_W'(1);
                r.entry_value  = chunk;
                r.entry_length = stored_len;
            end
        end
        r.distinct_count = DCNT_W'(table_used);
        return r;
    endfunction

    function automatic bit key_present(input logic [CHUNK_W-1:0] chunk);
        for (int k = 0; k < table_used; k++)
            if (table_keys[k] == chunk)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // check each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_table_results.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatch_count++;
            end else begin
                exp_r = pending_table_results.pop_front();
                check_field("status", exp_r.status, m_axis_tuser);
                check_field("position", exp_r.position, m_axis_tdata[7:0]);
                check_field("occurrences", exp_r.occurrences, m_axis_tdata[39:8]);
                check_field("entry_value", exp_r.entry_value, m_axis_tdata[55:40]);
                check_field("entry_length", exp_r.entry_length, m_axis_tdata[60:56]);
                check_field("distinct_count", exp_r.distinct_count, m_axis_tdata[69:61]);
            end
        end
    end

    // send one item; returns just after the accepting edge with tvalid still high
    task automatic send_item(
        input t_op                op,
        input logic [CHUNK_W-1:0] chunk,
        input logic [CLEN_W-1:0]  clen,
        input logic [EIDX_W-1:0]  idx
    );
        @(negedge i_clk);
        while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, idx, clen, chunk};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_table_results.push_back(apply_chunk_item(op, chunk, clen, idx));
    endtask

    // hold off the sender until every expected result has come
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_table_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [CLEN_W-1:0] pick_length();
        if ($urandom_range(99) < 10)
            return CLEN_W'($urandom_range(31));
        return CLEN_W'($urandom_range(16, 1));
    endfunction

    // empty-table reads, edge keys, length clamping, hits and shifts
    task automatic test_directed();
        send_item(OP_READ, 16'h0000, 5'd1, 8'h00);
        send_item(OP_READ, 16'hFFFF, 5'd31, 8'hFF);
        send_item(OP_ADD, 16'hFFFF, 5'd16, 8'hFF);
        send_item(OP_ADD, 16'h0000, 5'd0, 8'h00);
        send_item(OP_ADD, 16'h8000, 5'd31, 8'hAA);
        send_item(OP_ADD, 16'h8000, 5'd1, 8'h55);
        drain_results();
        send_item(OP_ADD, 16'h0000, 5'd5, 8'h00);
        send_item(OP_ADD, 16'hFFFF, 5'd16, 8'h01);
        send_item(OP_ADD, 16'h7FFF, 5'd17, 8'h80);
        send_item(OP_ADD, 16'h0001, 5'd16, 8'h7F);
        send_item(OP_ADD, 16'hFFFE, 5'd15, 8'hFE);
        for (int k = 0; k <= 6; k++)
            send_item(OP_READ, 16'h5555, 5'd8, 8'(k));
        send_item(OP_READ, 16'hAAAA, 5'd16, 8'hAA);
        send_item(OP_READ, 16'h0000, 5'd0, 8'h55);
        drain_results();
    endtask

    // random adds and reads, mostly on a small key pool so that hits are common
    task automatic test_random_traffic(input int n_items);
        logic [CHUNK_W-1:0] key_pool [POOL_SIZE];
        logic [CHUNK_W-1:0] chunk;
        logic [EIDX_W-1:0]  idx;
        foreach (key_pool[k])
            key_pool[k] = CHUNK_W'($urandom);
        for (int n = 0; n < n_items; n++) begin
            // run a long stretch without any stalls
            quiet_run = (n >= 250 && n < 450);
            chunk = ($urandom_range(99) < 70) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                              : CHUNK_W'($urandom);
            if (table_used > 0 && $urandom_range(99) < 80)
                idx = EIDX_W'($urandom_range(table_used - 1));
            else
                idx = EIDX_W'($urandom);
            if ($urandom_range(99) < 30)
                send_item(OP_READ, CHUNK_W'($urandom), pick_length(), idx);
            else
                send_item(OP_ADD, chunk, pick_length(), EIDX_W'($urandom));
        end
        quiet_run = 1'b0;
        drain_results();
    endtask

    // insert new keys until the table is at capacity, then overflow it
    task automatic test_fill_to_full();
        logic [CHUNK_W-1:0] chunk;
        while (table_used < TABLE_SLOTS + 2) begin
            chunk = CHUNK_W'($urandom);
            if (!key_present(chunk)) begin
                send_item(OP_ADD, chunk, pick_length(), EIDX_W'($urandom));
                if (table_used == TABLE_SLOTS)
                    break;
            end
        end
        // a new key now drops, an existing one still counts
        do chunk = CHUNK_W'($urandom); while (key_present(chunk));
        send_item(OP_ADD, chunk, 5'd16, 8'h00);
        send_item(OP_ADD, table_keys[TABLE_SLOTS-1], 5'd3, 8'hFF);
        send_item(OP_READ, 16'h0000, 5'd1, 8'hFF);
        drain_results();
    endtask

    // random traffic on a full table
    task automatic test_full_table(input int n_items);
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(2))
                0: send_item(OP_ADD, table_keys[$urandom_range(TABLE_SLOTS-1)],
                             pick_length(), EIDX_W'($urandom));
                1: send_item(OP_ADD, CHUNK_W'($urandom), pick_length(),
                             EIDX_W'($urandom));
                default: send_item(OP_READ, CHUNK_W'($urandom), pick_length(),
                                   EIDX_W'($urandom));
            endcase
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(700);
        test_fill_to_full();
        test_full_table(400);

        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
